// File: sv/dmix_pkg.sv
// Shared types and constants of the differential drive mixer.
// No dependencies; every module of the block imports this package.
package dmix_pkg;

   localparam int DEADBAND         = 16;
   localparam int MID_PULSE        = 1500;
   localparam int WEAPON_ON_PULSE  = 2000;
   localparam int WEAPON_OFF_PULSE = 1000;
   localparam int BIDIRECTIONAL    = 1;

   localparam int AXIS_W    = 10;
   localparam int PULSE_W   = 12;
   localparam int OUT_W     = 16;
   localparam int NUM_W     = 24;
   localparam int DEN_W     = 12;
   localparam int DIV_STEPS = NUM_W / 2;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_MIN_X      = 3'd2,
      CSR_MAX_X      = 3'd3,
      CSR_MIN_Y      = 3'd4,
      CSR_MAX_Y      = 3'd5,
      CSR_DRIVE_LOW  = 3'd6,
      CSR_DRIVE_HIGH = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_CLAMP,
      ST_MIX
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: sv/dmix_div.sv
// Iterative signed divider, two quotient bits per cycle, truncating toward zero.
// Depends on dmix_pkg for widths and the status struct.
module dmix_div
   import dmix_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DEN_W-1:0] den,
   output div_stat_type            stat,
   output logic signed [NUM_W-1:0] quot
);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] dmag_ff, dmag_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   t1, t2;
   logic             ge1, ge2;
   logic [DEN_W-1:0] r1;
   logic [NUM_W-1:0] q1;

   always_comb begin
      // first restoring step
      t1  = {rem_ff, quo_ff[NUM_W-1]};
      ge1 = (t1 >= {1'b0, dmag_ff});
      r1  = ge1 ? DEN_W'(t1 - {1'b0, dmag_ff}) : t1[DEN_W-1:0];
      q1  = {quo_ff[NUM_W-2:0], ge1};
      // second restoring step
      t2  = {r1, q1[NUM_W-1]};
      ge2 = (t2 >= {1'b0, dmag_ff});

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         quo_in  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         dmag_in = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
         neg_in  = num[NUM_W-1] ^ den[DEN_W-1];
         cnt_in  = CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge2 ? DEN_W'(t2 - {1'b0, dmag_ff}) : t2[DEN_W-1:0];
         quo_in = {q1[NUM_W-2:0], ge2};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = neg_ff ? $signed(-quo_ff) : $signed(quo_ff);

endmodule

// File: sv/dmix_mix.sv
// Saturation-compensating mix of throttle and steering into two pulse widths.
// Depends on dmix_pkg for widths; all sums are modulo 2^16.
module dmix_mix
   import dmix_pkg::*;
(
   input  logic signed [OUT_W-1:0] thr,
   input  logic signed [OUT_W-1:0] steer,
   input  logic [PULSE_W-1:0]      lo,
   input  logic [PULSE_W-1:0]      hi,
   output logic [OUT_W-1:0]        left_width,
   output logic [OUT_W-1:0]        right_width
);

   logic signed [OUT_W:0] sum_half;
   logic [OUT_W-1:0]      half, l0, r0, lb, rb, lo16, hi16;

   always_comb begin
      // halve with truncation toward zero
      sum_half = $signed({steer[OUT_W-1], steer}) + $signed({{OUT_W{1'b0}}, steer[OUT_W-1]});
      half     = sum_half[OUT_W:1];
      l0       = thr + half;
      r0       = thr - half;
      lo16     = {{(OUT_W-PULSE_W){1'b0}}, lo};
      hi16     = {{(OUT_W-PULSE_W){1'b0}}, hi};

      // low bound first, then high bound
      if (l0 < lo16)      lb = lo16;
      else if (l0 > hi16) lb = hi16;
      else                lb = l0;
      if (r0 < lo16)      rb = lo16;
      else if (r0 > hi16) rb = hi16;
      else                rb = r0;

      left_width  = (l0 != lb) ? lb : rb + steer;
      right_width = (r0 != rb) ? rb : lb - steer;
   end

endmodule

// File: sv/differential_drive_mixer_core.sv
// Top level of the differential drive mixer: sequencer, configuration and ports.
// Depends on dmix_pkg, dmix_div (shared divider) and dmix_mix (output mix).
//
// Usage:
//   req_* takes one joystick word: x_sample, y_sample and weapon_switch.
//   rsp_* returns one word per request: left, right and weapon pulse widths.
//   csr_* writes one of eight calibration registers; write only while idle.
// Each axis goes through a deadband test, a linear map and a clamp. The map
// uses one multiplier and one shared iterative divider that yields two
// quotient bits a cycle. An axis that sits inside the deadband or has a zero
// input span skips the multiply and divide steps. A new request is taken the
// cycle after the response is loaded, and a response may wait in the output
// register while the next request is already being worked on.
// When the receiver stalls, the finished word holds in the output register,
// and the sequencer waits in its mix step until that register frees up.
// Reset (synchronous, active high) restores the calibration defaults, clears
// the weapon arming latch, drops the response valid and returns to idle.
module differential_drive_mixer_core
   import dmix_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [9:0] x_sample, [19:10] y_sample, [20] weapon_switch, [23:21] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] left width, [31:16] right width, [43:32] weapon width, [47:44] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [PULSE_W-1:0]    csr_wdata
);

   // calibration registers
   logic [AXIS_W-1:0]  origin_x_ff, origin_y_ff, min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [PULSE_W-1:0] drive_low_ff, drive_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= AXIS_W'(512);
         origin_y_ff   <= AXIS_W'(512);
         min_x_ff      <= '0;
         max_x_ff      <= AXIS_W'(1023);
         min_y_ff      <= '0;
         max_y_ff      <= AXIS_W'(1023);
         drive_low_ff  <= PULSE_W'(1000);
         drive_high_ff <= PULSE_W'(2000);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:   origin_x_ff   <= csr_wdata[AXIS_W-1:0];
            CSR_ORIGIN_Y:   origin_y_ff   <= csr_wdata[AXIS_W-1:0];
            CSR_MIN_X:      min_x_ff      <= csr_wdata[AXIS_W-1:0];
            CSR_MAX_X:      max_x_ff      <= csr_wdata[AXIS_W-1:0];
            CSR_MIN_Y:      min_y_ff      <= csr_wdata[AXIS_W-1:0];
            CSR_MAX_Y:      max_y_ff      <= csr_wdata[AXIS_W-1:0];
            CSR_DRIVE_LOW:  drive_low_ff  <= csr_wdata;
            CSR_DRIVE_HIGH: drive_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and datapath registers
   state_type state_ff, state_in;
   logic      axis_ff, axis_in;         // 0 throttle, 1 steering
   logic      armed_ff, armed_in;
   logic      weap_on_ff, weap_on_in;
   logic [AXIS_W-1:0] x_ff, x_in, y_ff, y_in;

   logic signed [DEN_W-1:0] dv_ff, dv_in, span_ff, span_in;
   logic signed [12:0]      dc_ff, dc_in;
   logic signed [OUT_W-1:0] base_ff, base_in, map_ff, map_in;
   logic signed [OUT_W-1:0] thr_ff, thr_in, steer_ff, steer_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared divider
   logic                    div_start;
   logic signed [NUM_W-1:0] div_num;
   logic signed [NUM_W-1:0] prod;
   div_stat_type            div_stat;
   logic signed [NUM_W-1:0] div_quot;

   dmix_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (span_ff),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   logic [OUT_W-1:0] mix_left, mix_right;

   dmix_mix u_mix (
      .thr         (thr_ff),
      .steer       (steer_ff),
      .lo          (drive_low_ff),
      .hi          (drive_high_ff),
      .left_width  (mix_left),
      .right_width (mix_right)
   );

   // setup terms for the axis at hand
   logic [AXIS_W-1:0]       samp, org, b_raw;
   logic signed [DEN_W-1:0] v_s, o_hi, o_lo, a_s, b_s;
   logic signed [12:0]      lo13, hi13, d13, c13;
   logic signed [13:0]      dc14;
   logic                    above, below, active;
   logic signed [12:0]      lim_lo13, lim_hi13;
   logic signed [OUT_W-1:0] lim_lo, lim_hi, clamped;
   logic                    req_fire, out_free, sw;

   always_comb begin
      lo13 = $signed({1'b0, drive_low_ff});
      hi13 = $signed({1'b0, drive_high_ff});
      samp = axis_ff ? x_ff : y_ff;
      org  = axis_ff ? origin_x_ff : origin_y_ff;
      v_s  = $signed({2'b00, samp});
      o_hi = $signed({2'b00, org}) + $signed(DEN_W'(DEADBAND));
      o_lo = $signed({2'b00, org}) - $signed(DEN_W'(DEADBAND));
      above = (v_s > o_hi);
      below = (v_s < o_lo);
      // a one-way throttle treats everything below the upper deadband edge as rest
      active = above || (below && (axis_ff || BIDIRECTIONAL != 0));

      // choose map endpoints: a..b onto c..d
      a_s   = above ? o_hi : o_lo;
      b_raw = '0;
      d13   = '0;
      c13   = '0;
      if (!axis_ff) begin
         if (BIDIRECTIONAL != 0) begin
            c13   = 13'(MID_PULSE);
            b_raw = above ? max_y_ff : min_y_ff;
            d13   = above ? hi13 : lo13;
         end else begin
            c13   = lo13;
            b_raw = max_y_ff;
            d13   = hi13;
         end
      end else begin
         b_raw = above ? max_x_ff : min_x_ff;
         d13   = above ? (hi13 - lo13) : (lo13 - hi13);
      end
      b_s  = $signed({2'b00, b_raw});
      dc14 = $signed({d13[12], d13}) - $signed({c13[12], c13});

      // clamp limits for the axis at hand
      lim_lo13 = axis_ff ? (lo13 - hi13) : lo13;
      lim_hi13 = axis_ff ? (hi13 - lo13) : hi13;
      lim_lo   = $signed({{(OUT_W-13){lim_lo13[12]}}, lim_lo13});
      lim_hi   = $signed({{(OUT_W-13){lim_hi13[12]}}, lim_hi13});
      if (map_ff < lim_lo)      clamped = lim_lo;
      else if (map_ff > lim_hi) clamped = lim_hi;
      else                      clamped = map_ff;
   end

   assign prod    = NUM_W'(dv_ff) * NUM_W'(dc_ff);
   assign div_num = prod;

   assign sw       = req_tdata[2*AXIS_W];
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      armed_in     = armed_ff;
      weap_on_in   = weap_on_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dv_in        = dv_ff;
      span_in      = span_ff;
      dc_in        = dc_ff;
      base_in      = base_ff;
      map_in       = map_ff;
      thr_in       = thr_ff;
      steer_in     = steer_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               // arm on a low switch before forming the weapon output
               x_in       = req_tdata[AXIS_W-1:0];
               y_in       = req_tdata[2*AXIS_W-1:AXIS_W];
               armed_in   = armed_ff || !sw;
               weap_on_in = armed_ff && sw;
               axis_in    = 1'b0;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            dv_in   = v_s - a_s;
            span_in = b_s - a_s;
            dc_in   = dc14[12:0];
            base_in = $signed({{(OUT_W-13){c13[12]}}, c13});
            // inside the deadband or zero span: the map answers its start value
            if (!active || (b_s == a_s)) begin
               map_in   = $signed({{(OUT_W-13){c13[12]}}, c13});
               state_in = ST_CLAMP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               map_in   = div_quot[OUT_W-1:0] + base_ff;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (!axis_ff) begin
               thr_in   = clamped;
               axis_in  = 1'b1;
               state_in = ST_SETUP;
            end else begin
               steer_in = clamped;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000,
                               weap_on_ff ? PULSE_W'(WEAPON_ON_PULSE) : PULSE_W'(WEAPON_OFF_PULSE),
                               mix_right, mix_left};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff     <= axis_in;
      weap_on_ff  <= weap_on_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      dv_ff       <= dv_in;
      span_ff     <= span_in;
      dc_ff       <= dc_in;
      base_ff     <= base_in;
      map_ff      <= map_in;
      thr_ff      <= thr_in;
      steer_ff    <= steer_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the arming latch never drops outside reset
   a_armed_sticky: assert property (@(posedge clock) disable iff (reset)
      armed_ff |=> armed_ff)
      else $error("weapon arming latch cleared");

   // a high switch on an unarmed block never turns the weapon on
   a_weapon_needs_arm: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !armed_ff) |=> !weap_on_ff)
      else $error("weapon on without arming");

   // the divider is only started when idle
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // while waiting on a quotient the divider is working or just finished
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_stat.busy || div_stat.done))
      else $error("sequencer waits on an idle divider");

   // an accepted word starts with the throttle axis
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SETUP && !axis_ff))
      else $error("accepted word did not start throttle setup");

endmodule

// File: test/differential_drive_mixer_core_tb.sv
// Self-checking testbench for differential_drive_mixer_core: joystick words in, pulse words out.
// Depends on dmix_pkg (calibration indexes and mixer constants) and the mixer RTL under sv/.
module differential_drive_mixer_core_tb;
   import dmix_pkg::*;

   // Timing of the run
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake or register write
   localparam int PHASES         = 12;
   localparam int PHASE_WORDS    = 120;
   localparam int HOLD_AFTER     = 300;   // results seen before the long receiver hold
   localparam int HOLD_CYCLES    = 250;

   typedef struct packed {
      logic [9:0]  origin_x;
      logic [9:0]  origin_y;
      logic [9:0]  min_x;
      logic [9:0]  max_x;
      logic [9:0]  min_y;
      logic [9:0]  max_y;
      logic [11:0] drive_low;
      logic [11:0] drive_high;
   } cal_type;

   typedef struct packed {
      logic [9:0] x;
      logic [9:0] y;
      logic       sw;
   } stick_type;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
      logic [11:0] weapon;
   } pulse_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type idx;
      logic [11:0]   val;
      stick_type     js;
      logic          typed;
      pulse_type     want;
   } row_type;

   localparam cal_type RESET_CAL = '{origin_x: 10'd512, origin_y: 10'd512,
                                     min_x: 10'd0, max_x: 10'd1023,
                                     min_y: 10'd0, max_y: 10'd1023,
                                     drive_low: 12'd1000, drive_high: 12'd2000};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [9:0] x_sample, [19:10] y_sample, [20] weapon_switch, [23:21] zero
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [15:0] left width, [31:16] right width, [43:32] weapon width, [47:44] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [2:0]            csr_index;
   logic [PULSE_W-1:0]    csr_wdata;

   // Mirror of the block: calibration registers and the weapon arming latch
   cal_type   cal = RESET_CAL;
   logic      armed = 1'b0;

   pulse_type pending_pulses[$];
   row_type   script[$];

   int     words_sent      = 0;
   int     results_checked = 0;
   int     mismatches      = 0;
   int     settings_loaded = 0;
   logic   quiet_tail      = 1'b0;  // no idling on either side once set

   differential_drive_mixer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Mixer arithmetic, all on 64-bit signed values
   // ------------------------------------------------------------------

   // Wrap to 16-bit two's complement and sign-extend back
   function automatic longint wrap16(longint v);
      logic [15:0] u;
      u = v[15:0];
      return longint'($signed(u));
   endfunction

   // Keep the low 16 bits as a non-negative value
   function automatic longint low16(longint v);
      return {48'd0, v[15:0]};
   endfunction

   // Linear map with truncating division; a zero input span answers the start value
   function automatic longint span_map(longint v, longint a, longint b, longint c,
                                       longint d);
      if (b == a) begin
         return c;
      end
      return (v - a) * (d - c) / (b - a) + c;
   endfunction

   // Low bound tested first, so inverted bounds favor the low one
   function automatic longint bound(longint v, longint lo, longint hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // Work out the pulse word for one joystick word; updates the arming latch
   function automatic pulse_type mix_joystick(stick_type js);
      longint x, y, lo, hi, ox, oy, thr, steer, l0, r0, lb, rb, lp, rp;
      pulse_type p;
      x  = js.x;
      y  = js.y;
      lo = cal.drive_low;
      hi = cal.drive_high;
      ox = cal.origin_x;
      oy = cal.origin_y;
      if (!js.sw) begin
         armed = 1'b1;
      end
      // throttle from the vertical axis
      if (BIDIRECTIONAL != 0) begin
         if (y > oy + DEADBAND) begin
            thr = wrap16(span_map(y, oy + DEADBAND, cal.max_y, MID_PULSE, hi));
         end else if (y < oy - DEADBAND) begin
            thr = wrap16(span_map(y, oy - DEADBAND, cal.min_y, MID_PULSE, lo));
         end else begin
            thr = MID_PULSE;
         end
      end else begin
         if (y > oy + DEADBAND) begin
            thr = wrap16(span_map(y, oy + DEADBAND, cal.max_y, lo, hi));
         end else begin
            thr = lo;
         end
      end
      thr = wrap16(bound(thr, lo, hi));
      // steering from the horizontal axis
      if (x > ox + DEADBAND) begin
         steer = wrap16(span_map(x, ox + DEADBAND, cal.max_x, 0, hi - lo));
      end else if (x < ox - DEADBAND) begin
         steer = wrap16(span_map(x, ox - DEADBAND, cal.min_x, 0, lo - hi));
      end else begin
         steer = 0;
      end
      steer = wrap16(bound(steer, lo - hi, hi - lo));
      // saturation-compensating mix, modulo 2^16
      l0 = low16(thr + steer / 2);
      r0 = low16(thr - steer / 2);
      lb = bound(l0, lo, hi);
      rb = bound(r0, lo, hi);
      lp = (l0 != lb) ? lb : rb + steer;
      rp = (r0 != rb) ? rb : lb - steer;
      p.left   = lp[15:0];
      p.right  = rp[15:0];
      p.weapon = (armed && js.sw) ? PULSE_W'(WEAPON_ON_PULSE) : PULSE_W'(WEAPON_OFF_PULSE);
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic row_type sample_row(int x, int y, logic sw);
      row_type r;
      r.kind  = ROW_SAMPLE;
      r.idx   = CSR_ORIGIN_X;
      r.val   = '0;
      r.js    = '{x: x[9:0], y: y[9:0], sw: sw};
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   // Row whose result is typed in: left, right and weapon pulse widths
   function automatic row_type checked_row(int x, int y, logic sw, int l, int r, int w);
      row_type row;
      row       = sample_row(x, y, sw);
      row.typed = 1'b1;
      row.want  = '{left: l[15:0], right: r[15:0], weapon: w[11:0]};
      return row;
   endfunction

   function automatic row_type write_row(csr_index_type idx, int val);
      row_type r;
      r       = sample_row(0, 0, 1'b0);
      r.kind  = ROW_WRITE;
      r.idx   = idx;
      r.val   = val[11:0];
      return r;
   endfunction

   // Pick one axis reading: extremes, calibration bounds, deadband edges or anything
   function automatic logic [9:0] pick_axis(logic [9:0] origin, logic [9:0] lim_a,
                                            logic [9:0] lim_b);
      int v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = 1023;
         2: v = lim_a;
         3: v = lim_b;
         4, 5: v = int'(origin) + int'($urandom_range(0, 2 * DEADBAND + 4)) - DEADBAND - 2;
         default: v = $urandom_range(0, 1023);
      endcase
      if (v < 0) begin
         v = 0;
      end
      if (v > 1023) begin
         v = 1023;
      end
      return v[9:0];
   endfunction

   // Flavors: 0 reset values, 1 plausible calibration, 2 anything, 3 extremes
   function automatic cal_type random_calibration(int flavor);
      cal_type c;
      case (flavor)
         0: c = RESET_CAL;
         1: begin
            c.min_x      = $urandom_range(0, 200);
            c.max_x      = $urandom_range(800, 1023);
            c.origin_x   = $urandom_range(300, 700);
            c.min_y      = $urandom_range(0, 200);
            c.max_y      = $urandom_range(800, 1023);
            c.origin_y   = $urandom_range(300, 700);
            c.drive_low  = $urandom_range(500, 1400);
            c.drive_high = $urandom_range(1600, 2500);
         end
         2: begin
            c.origin_x   = $urandom_range(0, 1023);
            c.origin_y   = $urandom_range(0, 1023);
            c.min_x      = $urandom_range(0, 1023);
            c.max_x      = $urandom_range(0, 1023);
            c.min_y      = $urandom_range(0, 1023);
            c.max_y      = $urandom_range(0, 1023);
            c.drive_low  = $urandom_range(0, 4095);
            c.drive_high = $urandom_range(0, 4095);
         end
         default: begin
            c.origin_x   = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            c.origin_y   = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            c.min_x      = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            c.max_x      = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            c.min_y      = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            c.max_y      = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            c.drive_low  = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            c.drive_high = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         end
      endcase
      return c;
   endfunction

   // Write one calibration register and track it in the mirror.
   // Lower the write enable a step later so back-to-back writes never
   // lower and raise it in the same step.
   task automatic write_reg(csr_index_type idx, logic [11:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ORIGIN_X:   cal.origin_x   = val[9:0];
         CSR_ORIGIN_Y:   cal.origin_y   = val[9:0];
         CSR_MIN_X:      cal.min_x      = val[9:0];
         CSR_MAX_X:      cal.max_x      = val[9:0];
         CSR_MIN_Y:      cal.min_y      = val[9:0];
         CSR_MAX_Y:      cal.max_y      = val[9:0];
         CSR_DRIVE_LOW:  cal.drive_low  = val;
         CSR_DRIVE_HIGH: cal.drive_high = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_calibration(cal_type c);
      write_reg(CSR_ORIGIN_X,   {2'b00, c.origin_x});
      write_reg(CSR_ORIGIN_Y,   {2'b00, c.origin_y});
      write_reg(CSR_MIN_X,      {2'b00, c.min_x});
      write_reg(CSR_MAX_X,      {2'b00, c.max_x});
      write_reg(CSR_MIN_Y,      {2'b00, c.min_y});
      write_reg(CSR_MAX_Y,      {2'b00, c.max_y});
      write_reg(CSR_DRIVE_LOW,  c.drive_low);
      write_reg(CSR_DRIVE_HIGH, c.drive_high);
      settings_loaded++;
   endtask

   // Stop offering, drain every outstanding pulse word, then let the block settle
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (pending_pulses.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one joystick word, maybe after an idle burst, and record its
   // expected pulse word once the handshake completes
   task automatic send_sample(stick_type js, logic typed, pulse_type want, int idle_odds);
      pulse_type p;
      if (!quiet_tail && $urandom_range(0, idle_odds) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, js.sw, js.y, js.x};
      do begin
         @(posedge clock);
      end while (!req_tready);
      p = mix_joystick(js);
      if (typed) begin
         p = want;
      end
      pending_pulses.push_back(p);
      words_sent++;
   endtask

   // ------------------------------------------------------------------
   // Main sequence: reset, directed table, random calibration phases
   // ------------------------------------------------------------------
   initial begin : main_seq
      row_kind_type prev_kind;
      stick_type    js;
      int           idle_odds;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_ORIGIN_X;
      csr_wdata  <= '0;

      // After reset: weapon stays off until the switch has been seen low
      script.push_back(checked_row(512, 512, 1'b1, 1500, 1500, 1000));
      script.push_back(checked_row(1023, 1023, 1'b1, 2000, 1000, 1000));
      script.push_back(checked_row(0, 0, 1'b0, 1000, 2000, 1000));
      script.push_back(checked_row(512, 512, 1'b1, 1500, 1500, 2000));
      // full steer and full throttle each way
      script.push_back(checked_row(1023, 512, 1'b1, 2000, 1000, 2000));
      script.push_back(checked_row(0, 512, 1'b1, 1000, 2000, 2000));
      script.push_back(checked_row(512, 1023, 1'b0, 2000, 2000, 1000));
      script.push_back(checked_row(512, 0, 1'b1, 1000, 1000, 2000));
      // deadband edges: on the edge is still neutral, one count past is not
      script.push_back(checked_row(528, 528, 1'b1, 1500, 1500, 2000));
      script.push_back(checked_row(496, 496, 1'b1, 1500, 1500, 2000));
      script.push_back(sample_row(529, 529, 1'b1));
      script.push_back(sample_row(495, 495, 1'b0));
      // zero input span on steering right and throttle down
      script.push_back(write_row(CSR_MAX_X, 528));
      script.push_back(write_row(CSR_MIN_Y, 496));
      script.push_back(sample_row(600, 100, 1'b1));
      // inverted drive bounds
      script.push_back(write_row(CSR_MAX_X, 1023));
      script.push_back(write_row(CSR_MIN_Y, 0));
      script.push_back(write_row(CSR_DRIVE_LOW, 2000));
      script.push_back(write_row(CSR_DRIVE_HIGH, 1000));
      script.push_back(sample_row(1023, 1023, 1'b1));
      script.push_back(sample_row(0, 0, 1'b1));
      script.push_back(sample_row(512, 512, 1'b1));
      // deadband reaching below zero, widest drive range
      script.push_back(write_row(CSR_ORIGIN_X, 0));
      script.push_back(write_row(CSR_ORIGIN_Y, 5));
      script.push_back(write_row(CSR_DRIVE_LOW, 0));
      script.push_back(write_row(CSR_DRIVE_HIGH, 4095));
      script.push_back(sample_row(0, 0, 1'b1));
      script.push_back(sample_row(1023, 1023, 1'b1));
      script.push_back(sample_row(10, 3, 1'b1));
      // top-end origins with swapped axis bounds and fully inverted drive range
      script.push_back(write_row(CSR_ORIGIN_X, 1023));
      script.push_back(write_row(CSR_ORIGIN_Y, 1023));
      script.push_back(write_row(CSR_MIN_X, 1023));
      script.push_back(write_row(CSR_MAX_X, 0));
      script.push_back(write_row(CSR_MIN_Y, 1023));
      script.push_back(write_row(CSR_MAX_Y, 0));
      script.push_back(write_row(CSR_DRIVE_LOW, 4095));
      script.push_back(write_row(CSR_DRIVE_HIGH, 0));
      script.push_back(sample_row(0, 0, 1'b0));
      script.push_back(sample_row(1023, 1023, 1'b1));
      script.push_back(sample_row(1000, 1020, 1'b1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; drain before each group of register writes
      prev_kind = ROW_SAMPLE;
      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            if (prev_kind == ROW_SAMPLE) begin
               drain_and_settle();
            end
            write_reg(script[i].idx, script[i].val);
         end else begin
            send_sample(script[i].js, script[i].typed, script[i].want, 4);
         end
         prev_kind = script[i].kind;
      end

      // Random phases, each under a fresh calibration; the last one runs with no idling
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_and_settle();
         load_calibration(random_calibration(ph % 4));
         idle_odds = $urandom_range(1, 8);
         if (ph == PHASES - 1) begin
            quiet_tail = 1'b1;
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            js.x  = pick_axis(cal.origin_x, cal.min_x, cal.max_x);
            js.y  = pick_axis(cal.origin_y, cal.min_y, cal.max_y);
            js.sw = $urandom_range(0, 1);
            send_sample(js, 1'b0, '0, idle_odds);
         end
      end

      // Drain, then leave room for any stray extra word
      req_tvalid <= 1'b0;
      while (pending_pulses.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_pulses.size() != 0) begin
         mismatches += pending_pulses.size();
         $display("%0d pulse words never arrived", pending_pulses.size());
      end

      $display("Sent %0d joystick words under %0d calibration settings plus directed writes,",
               words_sent, settings_loaded);
      $display("checked %0d pulse words, %0d mismatches.", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("differential_drive_mixer_core_tb: done, clean");
      end else begin
         $display("differential_drive_mixer_core_tb: done, errors");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold so the block backs up
   // ------------------------------------------------------------------
   initial begin : receiver
      int  stall_left;
      logic long_hold_done;
      stall_left     = 0;
      long_hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && results_checked >= HOLD_AFTER) begin
            // hold off while the sender keeps offering, so the input stalls
            long_hold_done = 1'b1;
            stall_left     = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Checker: compare each accepted pulse word with the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin : pulse_checker
      pulse_type got;
      pulse_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left   = rsp_tdata[15:0];
         got.right  = rsp_tdata[31:16];
         got.weapon = rsp_tdata[43:32];
         if (pending_pulses.size() == 0) begin
            if (mismatches < 10) begin
               $display("%0t: unexpected pulse word left %0d right %0d weapon %0d",
                        $time, got.left, got.right, got.weapon);
            end
            mismatches++;
         end else begin
            want = pending_pulses.pop_front();
            if (got.left !== want.left || got.right !== want.right ||
                got.weapon !== want.weapon) begin
               if (mismatches < 10) begin
                  $display("%0t: word %0d expected left %0d right %0d weapon %0d, got %0d %0d %0d",
                           $time, results_checked, want.left, want.right, want.weapon,
                           got.left, got.right, got.weapon);
               end
               mismatches++;
            end
         end
         results_checked++;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if no handshake or write happens for too long
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Timed out after %0d cycles without a handshake", WATCHDOG_LIMIT);
      $display("differential_drive_mixer_core_tb: done, errors");
      $finish;
   end

endmodule
